>>> rtl/cbsi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the compressed block seek index.
// No dependencies; used by the top level and its checker.
package cbsi_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int OFF_W    = 48;
    localparam int SIZE_W   = 32;
    localparam int DIST_W   = 48;
    localparam int STATUS_W = 3;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PAST_END  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ORDER     = 3'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BS_RD,
        S_BS_CMP,
        S_CHK_RD,
        S_CHK_CMP,
        S_WK_RD,
        S_WK_CMP,
        S_RESP
    } state_t;

endpackage

>>> rtl/compressed_block_seek_index.sv
`timescale 1ns / 1ps
// Top level of the compressed block seek index: offset/size tables and search sequencer.
// Depends on cbsi_pkg.
//
// Seek index over up to 1024 compressed blocks. Append, clear and the unused kind are taken
// in the idle state; the result state then loads their result into the output register once
// it is free, and the next item can be accepted back in the idle state. A search is run by one
// sequencer over the two single-port tables (registered read), with a read state and a compare
// state per table access: a binary search for the start entry (one access per halving plus a
// closing range check), a match check, then one access per entry walked from the start entry,
// one more read state when the walk runs off the end, and the result state to load the result.
// The output register holds a finished result while the next item is accepted. Table contents
// need no clearing pass: only entries below the entry count are ever read.
module compressed_block_seek_index (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cbsi_pkg::KIND_W-1:0]       kind,
    input  logic [cbsi_pkg::OFF_W-1:0]        block_offset,
    input  logic [cbsi_pkg::SIZE_W-1:0]       entry_size,
    input  logic [cbsi_pkg::DIST_W-1:0]       skip_distance,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cbsi_pkg::STATUS_W-1:0]     status,
    output logic [cbsi_pkg::OFF_W-1:0]        target_offset,
    output logic [cbsi_pkg::DIST_W-1:0]       target_within
);

    localparam int IDX_W = cbsi_pkg::IDX_W;
    localparam int CNT_W = cbsi_pkg::CNT_W;

    // Tables
    logic [cbsi_pkg::OFF_W-1:0]  offset_mem [cbsi_pkg::TABLE_DEPTH];
    logic [cbsi_pkg::SIZE_W-1:0] size_mem   [cbsi_pkg::TABLE_DEPTH];
    logic [cbsi_pkg::OFF_W-1:0]  rd_off_reg;
    logic [cbsi_pkg::SIZE_W-1:0] rd_size_reg;
    logic                        rd_en;
    logic [IDX_W-1:0]            rd_addr;
    logic                        wr_en;

    // Control state
    cbsi_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    // Datapath registers
    logic [cbsi_pkg::OFF_W-1:0]    last_off_reg, last_off_next;
    logic [cbsi_pkg::OFF_W-1:0]    key_reg, key_next;
    logic [cbsi_pkg::DIST_W-1:0]   remain_reg, remain_next;
    logic [CNT_W-1:0]              lo_reg, lo_next;
    logic [CNT_W-1:0]              hi_reg, hi_next;
    logic [IDX_W-1:0]              mid_reg, mid_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic [cbsi_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [cbsi_pkg::OFF_W-1:0]    res_off_reg, res_off_next;
    logic [cbsi_pkg::DIST_W-1:0]   res_within_reg, res_within_next;
    logic [cbsi_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [cbsi_pkg::OFF_W-1:0]    toff_reg, toff_next;
    logic [cbsi_pkg::DIST_W-1:0]   within_reg, within_next;

    logic             accept;
    logic [CNT_W-1:0] mid_full;
    logic             full;
    logic             in_order;

    assign accept   = in_valid && in_ready;
    assign mid_full = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign full     = (count_reg == CNT_W'(cbsi_pkg::TABLE_DEPTH));
    assign in_order = (count_reg == '0) || (block_offset > last_off_reg);
    assign wr_en    = accept && (kind == cbsi_pkg::KIND_APPEND) && !full && in_order;

    // Write on append, read one entry of both tables per access
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            offset_mem[count_reg[IDX_W-1:0]] <= block_offset;
            size_mem[count_reg[IDX_W-1:0]]   <= entry_size;
        end
        if (rd_en)
        begin
            rd_off_reg  <= offset_mem[rd_addr];
            rd_size_reg <= size_mem[rd_addr];
        end
    end

    // Next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        last_off_next   = last_off_reg;
        key_next        = key_reg;
        remain_next     = remain_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_within_next = res_within_reg;
        status_next     = status_reg;
        toff_next       = toff_reg;
        within_next     = within_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        in_ready        = 1'b0;

        // Drop the output item once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            cbsi_pkg::S_IDLE:
            begin
                in_ready        = 1'b1;
                res_status_next = cbsi_pkg::ST_OK;
                res_off_next    = '0;
                res_within_next = '0;
                if (in_valid)
                begin
                    state_next = cbsi_pkg::S_RESP;
                    case (kind)
                        cbsi_pkg::KIND_APPEND:
                        begin
                            if (full)
                            begin
                                res_status_next = cbsi_pkg::ST_FULL;
                            end
                            else if (!in_order)
                            begin
                                res_status_next = cbsi_pkg::ST_ORDER;
                            end
                            else
                            begin
                                count_next    = count_reg + 1'b1;
                                last_off_next = block_offset;
                            end
                        end
                        cbsi_pkg::KIND_SEARCH:
                        begin
                            key_next    = block_offset;
                            remain_next = skip_distance;
                            lo_next     = '0;
                            hi_next     = count_reg;
                            state_next  = cbsi_pkg::S_BS_RD;
                        end
                        cbsi_pkg::KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default: ;
                    endcase
                end
            end

            // Halve the range or go check the landing entry
            cbsi_pkg::S_BS_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mid_full[IDX_W-1:0];
                    mid_next   = mid_full[IDX_W-1:0];
                    state_next = cbsi_pkg::S_BS_CMP;
                end
                else
                begin
                    state_next = cbsi_pkg::S_CHK_RD;
                end
            end

            cbsi_pkg::S_BS_CMP:
            begin
                if (rd_off_reg < key_reg)
                begin
                    lo_next = CNT_W'(mid_reg) + 1'b1;
                end
                else
                begin
                    hi_next = CNT_W'(mid_reg);
                end
                state_next = cbsi_pkg::S_BS_RD;
            end

            cbsi_pkg::S_CHK_RD:
            begin
                if (lo_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = lo_reg[IDX_W-1:0];
                    state_next = cbsi_pkg::S_CHK_CMP;
                end
                else
                begin
                    res_status_next = cbsi_pkg::ST_NOT_FOUND;
                    state_next      = cbsi_pkg::S_RESP;
                end
            end

            cbsi_pkg::S_CHK_CMP:
            begin
                if (rd_off_reg == key_reg)
                begin
                    idx_next   = lo_reg;
                    state_next = cbsi_pkg::S_WK_RD;
                end
                else
                begin
                    res_status_next = cbsi_pkg::ST_NOT_FOUND;
                    state_next      = cbsi_pkg::S_RESP;
                end
            end

            // Walk forward until the distance fits in a block
            cbsi_pkg::S_WK_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg[IDX_W-1:0];
                    state_next = cbsi_pkg::S_WK_CMP;
                end
                else
                begin
                    res_status_next = cbsi_pkg::ST_PAST_END;
                    state_next      = cbsi_pkg::S_RESP;
                end
            end

            cbsi_pkg::S_WK_CMP:
            begin
                if (remain_reg <= cbsi_pkg::DIST_W'(rd_size_reg))
                begin
                    res_status_next = cbsi_pkg::ST_OK;
                    res_off_next    = rd_off_reg;
                    res_within_next = remain_reg;
                    state_next      = cbsi_pkg::S_RESP;
                end
                else
                begin
                    remain_next = remain_reg - cbsi_pkg::DIST_W'(rd_size_reg);
                    idx_next    = idx_reg + 1'b1;
                    state_next  = cbsi_pkg::S_WK_RD;
                end
            end

            // Hand the result to the output register when it is free
            cbsi_pkg::S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    toff_next      = res_off_reg;
                    within_next    = res_within_reg;
                    state_next     = cbsi_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = cbsi_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cbsi_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        last_off_reg   <= last_off_next;
        key_reg        <= key_next;
        remain_reg     <= remain_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_within_reg <= res_within_next;
        status_reg     <= status_next;
        toff_reg       <= toff_next;
        within_reg     <= within_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign target_offset = toff_reg;
    assign target_within = within_reg;

endmodule

>>> rtl/cbsi_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the compressed block seek index, bound to the top level.
// Depends on cbsi_pkg and compressed_block_seek_index.
module cbsi_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic [cbsi_pkg::KIND_W-1:0]       kind,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [cbsi_pkg::STATUS_W-1:0]     status,
    input logic [cbsi_pkg::OFF_W-1:0]        target_offset,
    input logic [cbsi_pkg::DIST_W-1:0]       target_within
);

    // A waiting output item holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(target_offset) && $stable(target_within))
        else $error("output item changed while stalled");

    // Only a successful search carries a target
    a_zero_target: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != cbsi_pkg::ST_OK) |-> (target_offset == '0)
            && (target_within == '0))
        else $error("nonzero target on a failed item");

    // Status is always one of the five codes
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == cbsi_pkg::ST_OK) || (status == cbsi_pkg::ST_NOT_FOUND)
            || (status == cbsi_pkg::ST_PAST_END) || (status == cbsi_pkg::ST_FULL)
            || (status == cbsi_pkg::ST_ORDER))
        else $error("status code out of range");

    // One item at a time: the next cycle after an accept never accepts
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // An append taken while the output is free goes through the result state and then shows its own status
    a_append_status: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == cbsi_pkg::KIND_APPEND) && (!out_valid || out_ready)
            |-> ##2 out_valid && (status != cbsi_pkg::ST_NOT_FOUND)
            && (status != cbsi_pkg::ST_PAST_END))
        else $error("append reported a search status");

endmodule

bind compressed_block_seek_index cbsi_checker u_cbsi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .target_offset (target_offset),
    .target_within (target_within)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for compressed_block_seek_index: appends, searches and clears
// driven over valid/ready, every result checked against a scoreboard that mirrors the table.
// Depends on cbsi_pkg and compressed_block_seek_index.
module testbench;

    localparam int KIND_W      = cbsi_pkg::KIND_W;
    localparam int OFF_W       = cbsi_pkg::OFF_W;
    localparam int SIZE_W      = cbsi_pkg::SIZE_W;
    localparam int DIST_W      = cbsi_pkg::DIST_W;
    localparam int STATUS_W    = cbsi_pkg::STATUS_W;
    localparam int TABLE_DEPTH = cbsi_pkg::TABLE_DEPTH;
    localparam logic [KIND_W-1:0]   KIND_APPEND  = cbsi_pkg::KIND_APPEND;
    localparam logic [KIND_W-1:0]   KIND_SEARCH  = cbsi_pkg::KIND_SEARCH;
    localparam logic [KIND_W-1:0]   KIND_CLEAR   = cbsi_pkg::KIND_CLEAR;
    localparam logic [STATUS_W-1:0] ST_OK        = cbsi_pkg::ST_OK;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = cbsi_pkg::ST_NOT_FOUND;
    localparam logic [STATUS_W-1:0] ST_PAST_END  = cbsi_pkg::ST_PAST_END;
    localparam logic [STATUS_W-1:0] ST_FULL      = cbsi_pkg::ST_FULL;
    localparam logic [STATUS_W-1:0] ST_ORDER     = cbsi_pkg::ST_ORDER;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [OFF_W-1:0]  OFF_MAX     = '1;
    localparam logic [OFF_W-1:0]  BASE_ROOM   = 48'h1000_0000_0000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int QUIET_ITEMS  = 200;
    localparam int FILL_AFTER   = 300;
    localparam int IDLE_LIMIT   = 20000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [OFF_W-1:0]    offset;
        logic [DIST_W-1:0]   pos;
    } seek_result_t;

    // Mirror of the seek table and the queue of answers still owed by the block
    class seek_scoreboard;
        logic [OFF_W-1:0]  offsets [TABLE_DEPTH];
        logic [SIZE_W-1:0] sizes [TABLE_DEPTH];
        int count = 0;
        int mismatches = 0;
        seek_result_t answers_q [$];

        function int pending();
            return answers_q.size();
        endfunction

        // Apply one accepted item to the mirror and queue its answer
        function void note_item(logic [KIND_W-1:0] k, logic [OFF_W-1:0] offset,
                                logic [SIZE_W-1:0] size, logic [DIST_W-1:0] skip);
            seek_result_t r;
            int start;
            logic [DIST_W-1:0] remain;
            r = '0;
            start = -1;
            remain = skip;
            case (k)
                KIND_APPEND:
                begin
                    if (count >= TABLE_DEPTH)
                        r.st = ST_FULL;
                    else if (count > 0 && offset <= offsets[count-1])
                        r.st = ST_ORDER;
                    else
                    begin
                        offsets[count] = offset;
                        sizes[count] = size;
                        count++;
                    end
                end
                KIND_SEARCH:
                begin
                    for (int i = 0; i < count; i++)
                        if (start < 0 && offsets[i] == offset)
                            start = i;
                    if (start < 0)
                        r.st = ST_NOT_FOUND;
                    else
                    begin
                        // Walk forward until the remaining distance fits in a block
                        r.st = ST_PAST_END;
                        for (int i = start; i < count; i++)
                        begin
                            if (r.st == ST_PAST_END)
                            begin
                                if (remain <= DIST_W'(sizes[i]))
                                begin
                                    r.st = ST_OK;
                                    r.offset = offsets[i];
                                    r.pos = remain;
                                end
                                else
                                    remain = remain - DIST_W'(sizes[i]);
                            end
                        end
                    end
                end
                KIND_CLEAR:
                    count = 0;
                default:
                    ;
            endcase
            answers_q = {answers_q, r};
        endfunction

        // Compare one accepted result with the oldest answer owed
        function void check_result(logic [STATUS_W-1:0] st, logic [OFF_W-1:0] offset,
                                   logic [DIST_W-1:0] pos);
            seek_result_t want;
            if (answers_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%t: result with nothing owed: status=%0d offset=%h pos=%h",
                             $realtime, st, offset, pos);
            end
            else
            begin
                want = answers_q.pop_front();
                if (st !== want.st || offset !== want.offset || pos !== want.pos)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%t: expected st=%0d off=%h pos=%h, got st=%0d off=%h pos=%h",
                                 $realtime, want.st, want.offset, want.pos,
                                 st, offset, pos);
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [KIND_W-1:0]   kind;
    logic [OFF_W-1:0]    block_offset;
    logic [SIZE_W-1:0]   entry_size;
    logic [DIST_W-1:0]   skip_distance;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    target_offset;
    logic [DIST_W-1:0]   target_within;

    seek_scoreboard sb;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int gap_pct = 0;
    int sent = 0;

    compressed_block_seek_index DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .block_offset  (block_offset),
        .entry_size    (entry_size),
        .skip_distance (skip_distance),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .target_offset (target_offset),
        .target_within (target_within)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [OFF_W-1:0] rand48();
        return OFF_W'({$urandom, $urandom});
    endfunction

    function automatic int pick_pct();
        int r;
        r = $urandom_range(0, 3);
        return (r == 0) ? 0 : (r == 1) ? 5 : (r == 2) ? 15 : 30;
    endfunction

    // Block sizes: zero, small, all ones or anything
    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 50)
            return SIZE_W'($urandom_range(1, 15));
        if (r < 60)
            return '1;
        return SIZE_W'($urandom);
    endfunction

    // Next offset that keeps the table in ascending order
    function automatic logic [OFF_W-1:0] next_offset();
        logic [OFF_W-1:0] base;
        int r;
        r = $urandom_range(0, 99);
        if (sb.count == 0)
        begin
            base = rand48();
            if (r < 10)
                base = '0;
            else if (base > OFF_MAX - BASE_ROOM)
                base = OFF_MAX - BASE_ROOM;
            return base;
        end
        base = sb.offsets[sb.count-1];
        if (r < 60)
            return base + OFF_W'($urandom_range(1, 16));
        if (r < 90)
            return base + OFF_W'($urandom_range(1, 65536));
        return base + OFF_W'($urandom) + 1'b1;
    endfunction

    // Sum of block sizes from entry first up to, not including, entry last_idx
    function automatic logic [DIST_W-1:0] span_sum(int first, int last_idx);
        logic [DIST_W-1:0] d;
        d = '0;
        for (int i = first; i < last_idx; i++)
            d = d + DIST_W'(sb.sizes[i]);
        return d;
    endfunction

    // Offer one item, holding it until accepted, then book it
    task automatic send_item(input logic [KIND_W-1:0] k, input logic [OFF_W-1:0] off,
                             input logic [SIZE_W-1:0] size, input logic [DIST_W-1:0] skip);
        int gap;
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        block_offset <= off;
        entry_size <= size;
        skip_distance <= skip;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(k, off, size, skip);
        if (k != KIND_UNUSED)
            sent++;
    endtask

    // Drop valid and hold until every owed result has come back
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_append();
        send_item(KIND_APPEND, next_offset(), pick_size(), rand48());
    endtask

    // Broken items: non-increasing appends and the unused kind
    task automatic send_noise();
        logic [OFF_W-1:0] off;
        if (sb.count != 0 && $urandom_range(0, 99) < 60)
        begin
            off = rand48() % (sb.offsets[sb.count-1] + 1'b1);
            if ($urandom_range(0, 1) == 0)
                off = sb.offsets[sb.count-1];
            send_item(KIND_APPEND, off, pick_size(), rand48());
        end
        else
            send_item(KIND_UNUSED, rand48(), SIZE_W'($urandom), rand48());
    endtask

    // Search: mostly from a stored entry to a distance that lands in the table
    task automatic send_search(input int max_walk);
        int r;
        int first;
        int last_idx;
        logic [OFF_W-1:0] off;
        logic [DIST_W-1:0] skip;
        logic [DIST_W-1:0] room;
        r = $urandom_range(0, 99);
        if (sb.count == 0 || r < 10)
        begin
            off = rand48();
            if (sb.count != 0 && r < 5)
                off = sb.offsets[$urandom_range(0, sb.count - 1)] + 1'b1;
            skip = rand48();
        end
        else
        begin
            first = $urandom_range(0, sb.count - 1);
            off = sb.offsets[first];
            if (r < 20)
                skip = rand48();
            else if (r < 30)
                skip = span_sum(first, sb.count) + 1'b1 + DIST_W'($urandom_range(0, 255));
            else
            begin
                last_idx = first + $urandom_range(0, max_walk);
                if (last_idx > sb.count - 1)
                    last_idx = sb.count - 1;
                skip = span_sum(first, last_idx);
                room = DIST_W'(sb.sizes[last_idx]);
                r = $urandom_range(0, 99);
                if (r < 25)
                    skip = skip + room;
                else if (r < 75)
                    skip = skip + (DIST_W'($urandom) % (room + 1'b1));
            end
        end
        send_item(KIND_SEARCH, off, SIZE_W'($urandom), skip);
    endtask

    // One run: maybe clear, build a small table, then mostly search it
    task automatic run_episode();
        int n;
        int m;
        int r;
        gap_pct = pick_pct();
        if (sb.count >= 100 || $urandom_range(0, 99) < 80)
            send_item(KIND_CLEAR, rand48(), SIZE_W'($urandom), rand48());
        n = ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 40);
        repeat (n)
        begin
            if ($urandom_range(0, 99) < 10)
                send_noise();
            else
                send_append();
        end
        m = $urandom_range(2, 16);
        repeat (m)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                send_append();
            else if (r < 20)
                send_noise();
            else
                send_search(($urandom_range(0, 99) < 20) ? TABLE_DEPTH : 8);
        end
    endtask

    // Fill the table to the top, append past it and search across all of it
    task automatic run_fill();
        gap_pct = pick_pct();
        send_item(KIND_CLEAR, rand48(), SIZE_W'($urandom), rand48());
        while (sb.count < TABLE_DEPTH)
        begin
            if ($urandom_range(0, 99) < 3)
                send_noise();
            else
                send_append();
        end
        send_append();
        send_item(KIND_APPEND, sb.offsets[0], pick_size(), rand48());
        repeat (10) send_search(TABLE_DEPTH);
        send_item(KIND_SEARCH, sb.offsets[0], SIZE_W'($urandom), span_sum(0, TABLE_DEPTH));
        send_item(KIND_SEARCH, sb.offsets[0], SIZE_W'($urandom),
                  span_sum(0, TABLE_DEPTH) + 1'b1);
        pause_until_drained();
        send_item(KIND_CLEAR, rand48(), SIZE_W'($urandom), rand48());
    endtask

    // Result side: accept with random stall bursts and one long hold
    initial
    begin
        int stall_left;
        int hold_left;
        int stall_pct;
        int cycles;
        bit ready_next;
        stall_left = 0;
        hold_left = 0;
        stall_pct = 0;
        cycles = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(status, target_offset, target_within);
            cycles++;
            if (cycles % 256 == 0)
                stall_pct = pick_pct();
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                ready_next = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                ready_next = 1'b0;
            end
            else
                ready_next = 1'b1;
            out_ready <= ready_next;
        end
    end

    // Watchdog: end the run if nothing moves for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Stimulus
    initial
    begin
        bit filled;
        filled = 1'b0;
        sb = new;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_APPEND;
        block_offset = '0;
        entry_size = '0;
        skip_distance = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, unused kind, ordering, zero and full-size blocks, walks
        send_item(KIND_SEARCH, '0, '0, '0);
        send_item(KIND_UNUSED, OFF_MAX, '1, OFF_MAX);
        send_item(KIND_APPEND, '0, '0, '0);
        send_item(KIND_APPEND, '0, 32'd7, '0);
        send_item(KIND_APPEND, 48'd5, '1, '0);
        send_item(KIND_APPEND, 48'd3, 32'd1, '0);
        send_item(KIND_APPEND, 48'd100, 32'd10, '0);
        send_item(KIND_SEARCH, '0, '0, '0);
        send_item(KIND_SEARCH, '0, '0, 48'd1);
        send_item(KIND_SEARCH, 48'd5, '0, 48'h0000_FFFF_FFFF);
        send_item(KIND_SEARCH, 48'd5, '0, 48'h0001_0000_0000);
        send_item(KIND_SEARCH, 48'd5, '0, 48'h0001_0000_000A);
        send_item(KIND_SEARCH, 48'd7, '0, '0);
        send_item(KIND_SEARCH, 48'd100, '1, OFF_MAX);
        send_item(KIND_APPEND, OFF_MAX, 32'h8000_0000, '0);
        send_item(KIND_SEARCH, OFF_MAX, '0, 48'h0000_8000_0000);
        send_item(KIND_APPEND, OFF_MAX, 32'd1, '0);
        send_item(KIND_CLEAR, '0, '0, '0);
        send_item(KIND_SEARCH, '0, '0, '0);
        send_item(KIND_APPEND, 48'h8000_0000_0000, 32'd1, '0);
        send_item(KIND_SEARCH, 48'h8000_0000_0000, '0, 48'd2);
        send_item(KIND_CLEAR, OFF_MAX, '1, OFF_MAX);
        pause_until_drained();

        // Random: the first run backs up the block behind a long result hold
        sent = 0;
        hold_req = 1'b1;
        run_episode();
        pause_until_drained();
        while (sent < RANDOM_ITEMS)
        begin
            if (!filled && sent >= FILL_AFTER)
            begin
                run_fill();
                filled = 1'b1;
            end
            else
                run_episode();
            if (sent >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
        end

        // Wait out the remaining results, then give the block time to misbehave
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cbsi_pkg.sv
rtl/compressed_block_seek_index.sv
rtl/cbsi_checker.sv
tb/testbench.sv
